/* sv/pmf_pkg.sv */
// Shared types and constants for the priority merge FIFO block.
// Used by every module under sv/; no dependencies of its own.
package pmf_pkg;

  localparam int SRC_DEPTH = 16;
  localparam int UNI_CAP   = 10;
  localparam int SRC_CNT_W = $clog2(SRC_DEPTH + 1);
  localparam int UNI_CNT_W = $clog2(UNI_CAP + 1);
  localparam int TICKET_W  = 32;

  typedef logic signed [TICKET_W-1:0] ticket_t;

  typedef enum logic [1:0] {
    KIND_ADD_NORMAL = 2'd0,
    KIND_ADD_HIGH   = 2'd1,
    KIND_REMOVE     = 2'd2,
    KIND_MERGE      = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    STAT_OK         = 3'd0,
    STAT_BOTH_EMPTY = 3'd1,
    STAT_UNI_FULL   = 3'd2,
    STAT_UNI_EMPTY  = 3'd3,
    STAT_SRC_FULL   = 3'd4
  } status_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_MERGE = 1'b1
  } state_t;

  typedef struct packed {
    kind_t   kind;
    ticket_t ticket;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    ticket_t     removed_ticket;
    logic [3:0]  moved_count;
    logic [3:0]  unified_count;
    logic [4:0]  high_count;
    logic [4:0]  normal_count;
  } out_item_t;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctl_t;

endpackage

/* sv/pmf_cell.sv */
// One storage cell of a shifting ticket chain.
// Depends on pmf_pkg for the ticket type.
module pmf_cell (
  input  logic             clk,
  input  logic             load_en,
  input  logic             shift_en,
  input  pmf_pkg::ticket_t load_data,
  input  pmf_pkg::ticket_t shift_data,
  output pmf_pkg::ticket_t data
);

  pmf_pkg::ticket_t data_r;

  always_ff @(posedge clk) begin
    if (load_en) begin
      data_r <= load_data;
    end else if (shift_en) begin
      data_r <= shift_data;
    end
  end

  assign data = data_r;

endmodule

/* sv/pmf_src_fifo.sv */
// Source ticket queue: a chain of pmf_cell entries that shifts toward the head on pop.
// Depends on pmf_pkg and pmf_cell.
module pmf_src_fifo (
  input  logic                             clk,
  input  logic                             rst_n,
  input  pmf_pkg::fifo_ctl_t               ctl,
  input  pmf_pkg::ticket_t                 push_data,
  output pmf_pkg::ticket_t                 head_data,
  output logic [pmf_pkg::SRC_CNT_W-1:0]    fill
);

  logic [pmf_pkg::SRC_CNT_W-1:0] fill_r;
  logic [pmf_pkg::SRC_CNT_W-1:0] fill_nxt;
  logic [pmf_pkg::SRC_CNT_W-1:0] wr_idx;
  pmf_pkg::ticket_t              cell_q  [pmf_pkg::SRC_DEPTH];
  pmf_pkg::ticket_t              shift_d [pmf_pkg::SRC_DEPTH];

  assign wr_idx = ctl.pop ? fill_r - pmf_pkg::SRC_CNT_W'(1) : fill_r;

  always_comb begin
    fill_nxt = fill_r;
    if (ctl.push && !ctl.pop) begin
      fill_nxt = fill_r + pmf_pkg::SRC_CNT_W'(1);
    end else if (ctl.pop && !ctl.push) begin
      fill_nxt = fill_r - pmf_pkg::SRC_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  for (genvar i = 0; i < pmf_pkg::SRC_DEPTH; i++) begin : g_cell
    if (i < pmf_pkg::SRC_DEPTH - 1) begin : g_mid
      assign shift_d[i] = cell_q[i+1];
    end else begin : g_last
      assign shift_d[i] = '0;
    end
    pmf_cell u_cell (
      .clk        (clk),
      .load_en    (ctl.push && (wr_idx == pmf_pkg::SRC_CNT_W'(i))),
      .shift_en   (ctl.pop),
      .load_data  (push_data),
      .shift_data (shift_d[i]),
      .data       (cell_q[i])
    );
  end

  assign head_data = cell_q[0];
  assign fill      = fill_r;

endmodule

/* sv/pmf_uni_fifo.sv */
// Unified output queue: a chain of pmf_cell entries that shifts toward the head on pop.
// Depends on pmf_pkg and pmf_cell.
module pmf_uni_fifo (
  input  logic                             clk,
  input  logic                             rst_n,
  input  pmf_pkg::fifo_ctl_t               ctl,
  input  pmf_pkg::ticket_t                 push_data,
  output pmf_pkg::ticket_t                 head_data,
  output logic [pmf_pkg::UNI_CNT_W-1:0]    fill
);

  logic [pmf_pkg::UNI_CNT_W-1:0] fill_r;
  logic [pmf_pkg::UNI_CNT_W-1:0] fill_nxt;
  logic [pmf_pkg::UNI_CNT_W-1:0] wr_idx;
  pmf_pkg::ticket_t              cell_q  [pmf_pkg::UNI_CAP];
  pmf_pkg::ticket_t              shift_d [pmf_pkg::UNI_CAP];

  assign wr_idx = ctl.pop ? fill_r - pmf_pkg::UNI_CNT_W'(1) : fill_r;

  always_comb begin
    fill_nxt = fill_r;
    if (ctl.push && !ctl.pop) begin
      fill_nxt = fill_r + pmf_pkg::UNI_CNT_W'(1);
    end else if (ctl.pop && !ctl.push) begin
      fill_nxt = fill_r - pmf_pkg::UNI_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  for (genvar i = 0; i < pmf_pkg::UNI_CAP; i++) begin : g_cell
    if (i < pmf_pkg::UNI_CAP - 1) begin : g_mid
      assign shift_d[i] = cell_q[i+1];
    end else begin : g_last
      assign shift_d[i] = '0;
    end
    pmf_cell u_cell (
      .clk        (clk),
      .load_en    (ctl.push && (wr_idx == pmf_pkg::UNI_CNT_W'(i))),
      .shift_en   (ctl.pop),
      .load_data  (push_data),
      .shift_data (shift_d[i]),
      .data       (cell_q[i])
    );
  end

  assign head_data = cell_q[0];
  assign fill      = fill_r;

endmodule

/* sv/priority_merge_into_bounded_fifo.sv */
// Strict-priority merge of a high and a normal ticket queue into a bounded unified queue.
// Depends on pmf_pkg, pmf_src_fifo and pmf_uni_fifo.
//
// Input channel in_valid/in_stall/in_data carries one request per transfer: add a ticket
// to the normal or high queue, remove the head of the unified queue, or merge.
// Every request answers with exactly one result on out_valid/out_stall/out_data.
// Adds and removes finish in the accept cycle; the result is valid on the next cycle.
// A merge moves one ticket per cycle from the high queue, then the normal queue, into
// the unified queue until it is full or both sources are empty; the result reports
// the number moved in moved_count. The single move path between the source chains
// and the unified chain sets that rate.
// Only one request is in flight; in_stall is high while a merge runs or while a
// result waits in the output register under out_stall.
// Synchronous reset empties all three queues and drops any pending result; no
// clearing pass is needed. While out_stall is high a pending result holds and no new
// request is taken.
module priority_merge_into_bounded_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pmf_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pmf_pkg::out_item_t  out_data
);

  pmf_pkg::state_t               state_r;
  pmf_pkg::state_t               state_nxt;
  logic [pmf_pkg::UNI_CNT_W-1:0] moved_r;
  logic [pmf_pkg::UNI_CNT_W-1:0] moved_nxt;
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  pmf_pkg::out_item_t            out_data_r;
  pmf_pkg::out_item_t            out_data_nxt;

  pmf_pkg::fifo_ctl_t            high_ctl;
  pmf_pkg::fifo_ctl_t            norm_ctl;
  pmf_pkg::fifo_ctl_t            uni_ctl;
  pmf_pkg::ticket_t              high_head;
  pmf_pkg::ticket_t              norm_head;
  pmf_pkg::ticket_t              uni_head;
  pmf_pkg::ticket_t              uni_push_data;
  logic [pmf_pkg::SRC_CNT_W-1:0] high_fill;
  logic [pmf_pkg::SRC_CNT_W-1:0] norm_fill;
  logic [pmf_pkg::UNI_CNT_W-1:0] uni_fill;

  logic accept;
  logic out_take;
  logic high_full;
  logic norm_full;
  logic high_empty;
  logic norm_empty;
  logic uni_full;
  logic uni_empty;

  assign high_full  = (high_fill == pmf_pkg::SRC_CNT_W'(pmf_pkg::SRC_DEPTH));
  assign norm_full  = (norm_fill == pmf_pkg::SRC_CNT_W'(pmf_pkg::SRC_DEPTH));
  assign high_empty = (high_fill == '0);
  assign norm_empty = (norm_fill == '0);
  assign uni_full   = (uni_fill == pmf_pkg::UNI_CNT_W'(pmf_pkg::UNI_CAP));
  assign uni_empty  = (uni_fill == '0);

  assign out_take = out_valid_r && !out_stall;
  assign in_stall = (state_r != pmf_pkg::ST_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt     = state_r;
    moved_nxt     = moved_r;
    out_valid_nxt = out_valid_r && !out_take;
    out_data_nxt  = out_data_r;
    high_ctl      = '0;
    norm_ctl      = '0;
    uni_ctl       = '0;
    uni_push_data = high_empty ? norm_head : high_head;

    unique case (state_r)
      pmf_pkg::ST_IDLE: begin
        if (accept) begin
          out_data_nxt.status         = pmf_pkg::STAT_OK;
          out_data_nxt.removed_ticket = '0;
          out_data_nxt.moved_count    = '0;
          out_data_nxt.unified_count  = 4'(uni_fill);
          out_data_nxt.high_count     = 5'(high_fill);
          out_data_nxt.normal_count   = 5'(norm_fill);
          out_valid_nxt               = 1'b1;
          unique case (in_data.kind)
            pmf_pkg::KIND_ADD_NORMAL: begin
              if (norm_full) begin
                out_data_nxt.status = pmf_pkg::STAT_SRC_FULL;
              end else begin
                norm_ctl.push             = 1'b1;
                out_data_nxt.normal_count = 5'(norm_fill + pmf_pkg::SRC_CNT_W'(1));
              end
            end
            pmf_pkg::KIND_ADD_HIGH: begin
              if (high_full) begin
                out_data_nxt.status = pmf_pkg::STAT_SRC_FULL;
              end else begin
                high_ctl.push           = 1'b1;
                out_data_nxt.high_count = 5'(high_fill + pmf_pkg::SRC_CNT_W'(1));
              end
            end
            pmf_pkg::KIND_REMOVE: begin
              if (uni_empty) begin
                out_data_nxt.status = pmf_pkg::STAT_UNI_EMPTY;
              end else begin
                uni_ctl.pop                 = 1'b1;
                out_data_nxt.removed_ticket = uni_head;
                out_data_nxt.unified_count  = 4'(uni_fill - pmf_pkg::UNI_CNT_W'(1));
              end
            end
            pmf_pkg::KIND_MERGE: begin
              if (high_empty && norm_empty) begin
                out_data_nxt.status = pmf_pkg::STAT_BOTH_EMPTY;
              end else if (uni_full) begin
                out_data_nxt.status = pmf_pkg::STAT_UNI_FULL;
              end else begin
                out_valid_nxt = 1'b0;
                moved_nxt     = '0;
                state_nxt     = pmf_pkg::ST_MERGE;
              end
            end
            default: begin
              out_valid_nxt = out_valid_r && !out_take;
            end
          endcase
        end
      end
      pmf_pkg::ST_MERGE: begin
        if (!uni_full && !(high_empty && norm_empty)) begin
          uni_ctl.push = 1'b1;
          high_ctl.pop = !high_empty;
          norm_ctl.pop = high_empty;
          moved_nxt    = moved_r + pmf_pkg::UNI_CNT_W'(1);
        end else begin
          out_data_nxt.status         = pmf_pkg::STAT_OK;
          out_data_nxt.removed_ticket = '0;
          out_data_nxt.moved_count    = 4'(moved_r);
          out_data_nxt.unified_count  = 4'(uni_fill);
          out_data_nxt.high_count     = 5'(high_fill);
          out_data_nxt.normal_count   = 5'(norm_fill);
          out_valid_nxt               = 1'b1;
          state_nxt                   = pmf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pmf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pmf_pkg::ST_IDLE;
      moved_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      moved_r     <= moved_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  pmf_src_fifo u_high (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (high_ctl),
    .push_data (in_data.ticket),
    .head_data (high_head),
    .fill      (high_fill)
  );

  pmf_src_fifo u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (norm_ctl),
    .push_data (in_data.ticket),
    .head_data (norm_head),
    .fill      (norm_fill)
  );

  pmf_uni_fifo u_uni (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (uni_ctl),
    .push_data (uni_push_data),
    .head_data (uni_head),
    .fill      (uni_fill)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
